/* hw/rtl/rvad_pkg.sv */
// ----------------------------------------------------------------------------
// rvad_pkg: shared types and constants of the RMS voice activity detector
// Holds the transaction payloads, the frame job that passes from the
// accumulator to the back end, and the fixed field widths.
// ----------------------------------------------------------------------------
package rvad_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 39;
	localparam int CNT_W      = 9;
	localparam int TIME_W     = 48;
	localparam int THR_W      = 16;
	localparam int HOLD_W     = 24;
	localparam int RAD_W      = 32;
	localparam int ROOT_W     = 16;
	localparam int SQREM_W    = ROOT_W + 2;
	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int ITER_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RMS_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_HOLD_US = 2'd1;

	localparam logic [THR_W-1:0]  THR_RESET  = 16'd500;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd1000000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_last;
		logic [TIME_W-1:0]          time_us;
		logic                       link_up;
		logic                       start_ok;
		logic                       end_ok;
	} in_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rms_level;
		logic              voiced;
		logic              activity_on;
		logic              start_event;
		logic              end_event;
		logic              forward_audio;
	} out_t;

	// One finished frame waiting for the divide, root and decision
	typedef struct packed {
		logic [SUM_W-1:0]  square_sum;
		logic [CNT_W-1:0]  sample_count;
		logic [TIME_W-1:0] time_us;
		logic              link_up;
		logic              start_ok;
		logic              end_ok;
	} job_t;

	typedef struct packed {
		logic [THR_W-1:0]  rms_threshold;
		logic [HOLD_W-1:0] silence_hold_us;
	} cfg_t;

endpackage

/* hw/rtl/rvad_front.sv */
// ----------------------------------------------------------------------------
// rvad_front: sample accumulator
// Squares each accepted sample into a running sum and count, and hands the
// totals of a frame to the job queue on the frame-end sample.
// ----------------------------------------------------------------------------
module rvad_front #(
	parameter int FRAME_SAMPLES = 320
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  rvad_pkg::in_t            sample_data,
	output logic                     push,
	output rvad_pkg::job_t           push_job,
	input  logic                     queue_full
);

	localparam logic [rvad_pkg::CNT_W-1:0] FRAME_MAX = rvad_pkg::CNT_W'(FRAME_SAMPLES);

	logic [rvad_pkg::SUM_W-1:0] sum_q;
	logic [rvad_pkg::CNT_W-1:0] count_q;
	logic signed [31:0]         square;
	logic [rvad_pkg::SUM_W-1:0] sum_next;
	logic [rvad_pkg::CNT_W-1:0] count_next;
	logic                       accept;

	// Hold the sample side while the queue has no room for a frame
	assign sample_stall = queue_full;
	assign accept       = sample_valid && !sample_stall;

	assign square = sample_data.sample * sample_data.sample;

	// Accumulate only while the frame is below its sample limit
	always_comb begin
		sum_next   = sum_q;
		count_next = count_q;
		if (count_q < FRAME_MAX) begin
			sum_next   = sum_q + rvad_pkg::SUM_W'(unsigned'(square));
			count_next = count_q + 1'b1;
		end
	end

	assign push                  = accept && sample_data.frame_last;
	assign push_job.square_sum   = sum_next;
	assign push_job.sample_count = count_next;
	assign push_job.time_us      = sample_data.time_us;
	assign push_job.link_up      = sample_data.link_up;
	assign push_job.start_ok     = sample_data.start_ok;
	assign push_job.end_ok       = sample_data.end_ok;

	// Advance the totals, clear them at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (sample_data.frame_last) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_next;
			end
		end
	end

endmodule

/* hw/rtl/rvad_queue.sv */
// ----------------------------------------------------------------------------
// rvad_queue: frame job queue
// Short first-in first-out buffer that decouples the accumulator from the
// divide, root and decision back end.
// ----------------------------------------------------------------------------
module rvad_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rvad_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output rvad_pkg::job_t head_job,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

	rvad_pkg::job_t      entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [LVL_W-1:0]    level_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (level_q == LVL_FULL);
	assign empty    = (level_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = entry_q[rd_ptr_q];

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/rvad_back.sv */
// ----------------------------------------------------------------------------
// rvad_back: frame back end
// Divides the frame's square sum by its count one quotient bit a cycle,
// takes the integer square root two radicand bits a cycle, then runs the
// activity and hangover decision into the result register.
// ----------------------------------------------------------------------------
module rvad_back #(
	parameter int TIME_BITS = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rvad_pkg::cfg_t cfg,
	input  logic           job_ready,
	input  rvad_pkg::job_t job,
	output logic           job_pop,
	output logic           result_valid,
	input  logic           result_stall,
	output rvad_pkg::out_t result_data
);

	localparam int TW = TIME_BITS;
	localparam int DREM_W = rvad_pkg::CNT_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [rvad_pkg::ITER_W-1:0] DIV_LAST  = rvad_pkg::ITER_W'(rvad_pkg::DIV_STEPS - 1);
	localparam logic [rvad_pkg::ITER_W-1:0] SQRT_LAST = rvad_pkg::ITER_W'(rvad_pkg::SQRT_STEPS - 1);

	logic [1:0]                      state_q;
	logic [rvad_pkg::ITER_W-1:0]     iter_q;

	// Frame job fields held for the decision
	logic [TW-1:0]                   now_q;
	logic                            link_q;
	logic                            start_ok_q;
	logic                            end_ok_q;

	// Divider: dividend shifts out, quotient shifts in
	logic [rvad_pkg::SUM_W-1:0]      dvd_q;
	logic [rvad_pkg::CNT_W-1:0]      dvs_q;
	logic [rvad_pkg::CNT_W-1:0]      drem_q;
	logic [DREM_W-1:0]               drem_shift;
	logic                            qbit;
	logic [DREM_W-1:0]               drem_diff;

	// Root: radicand shifts out two bits a step
	logic [rvad_pkg::RAD_W-1:0]      rad_q;
	logic [rvad_pkg::SQREM_W-1:0]    srem_q;
	logic [rvad_pkg::ROOT_W-1:0]     root_q;
	logic [rvad_pkg::SQREM_W-1:0]    srem_shift;
	logic [rvad_pkg::SQREM_W-1:0]    trial;
	logic                            rbit;

	// Activity state
	logic                            activity_q;
	logic                            pending_q;
	logic [TW-1:0]                   sstart_q;

	// Result register
	logic                            out_valid_q;
	rvad_pkg::out_t                  out_q;

	// Decision
	logic                            out_free;
	logic                            voiced;
	logic [TW-1:0]                   span_start;
	logic [TW-1:0]                   elapsed;
	logic                            hold_done;
	logic                            act_next;
	logic                            pend_next;
	logic [TW-1:0]                   sstart_next;
	logic                            start_ev;
	logic                            end_ev;
	logic                            fwd;

	assign job_pop      = (state_q == ST_IDLE) && job_ready;
	assign result_valid = out_valid_q;
	assign result_data  = out_q;
	assign out_free     = !out_valid_q || !result_stall;

	// One restoring divide step
	assign drem_shift = {drem_q, dvd_q[rvad_pkg::SUM_W-1]};
	assign qbit       = (drem_shift >= {1'b0, dvs_q});
	assign drem_diff  = drem_shift - {1'b0, dvs_q};

	// One digit-by-digit root step
	assign srem_shift = {srem_q[rvad_pkg::SQREM_W-3:0], rad_q[rvad_pkg::RAD_W-1 -: 2]};
	assign trial      = {root_q, 2'b01};
	assign rbit       = (srem_shift >= trial);

	// Activity and hangover decision on the finished root
	assign voiced     = (root_q >= cfg.rms_threshold);
	assign span_start = pending_q ? sstart_q : now_q;
	assign elapsed    = now_q - span_start;
	assign hold_done  = (elapsed >= TW'(cfg.silence_hold_us));

	always_comb begin
		act_next    = activity_q;
		pend_next   = pending_q;
		sstart_next = sstart_q;
		start_ev    = 1'b0;
		end_ev      = 1'b0;
		fwd         = 1'b0;
		if (link_q) begin
			if (voiced) begin
				pend_next = 1'b0;
				if (!activity_q && start_ok_q) begin
					act_next = 1'b1;
					start_ev = 1'b1;
				end
				fwd = activity_q || start_ok_q;
			end else if (activity_q) begin
				if (!pending_q) begin
					pend_next   = 1'b1;
					sstart_next = now_q;
				end
				if (hold_done && end_ok_q) begin
					act_next  = 1'b0;
					pend_next = 1'b0;
					end_ev    = 1'b1;
				end
			end
		end else begin
			act_next    = 1'b0;
			pend_next   = 1'b0;
			sstart_next = '0;
		end
	end

	// Sequence divide, root and decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			activity_q  <= 1'b0;
			pending_q   <= 1'b0;
			sstart_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result, or drop the one just taken
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_ready) begin
						iter_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (iter_q == DIV_LAST) begin
						iter_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (iter_q == SQRT_LAST) begin
						state_q <= ST_EMIT;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						activity_q  <= act_next;
						pending_q   <= pend_next;
						sstart_q    <= sstart_next;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dvd_q      <= job.square_sum;
				dvs_q      <= job.sample_count;
				drem_q     <= '0;
				now_q      <= TW'(job.time_us);
				link_q     <= job.link_up;
				start_ok_q <= job.start_ok;
				end_ok_q   <= job.end_ok;
			end
			ST_DIV: begin
				dvd_q  <= {dvd_q[rvad_pkg::SUM_W-2:0], qbit};
				drem_q <= qbit ? drem_diff[rvad_pkg::CNT_W-1:0]
				               : drem_shift[rvad_pkg::CNT_W-1:0];
				if (iter_q == DIV_LAST) begin
					rad_q  <= {dvd_q[rvad_pkg::RAD_W-2:0], qbit};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				rad_q  <= {rad_q[rvad_pkg::RAD_W-3:0], 2'b00};
				srem_q <= rbit ? srem_shift - trial : srem_shift;
				root_q <= {root_q[rvad_pkg::ROOT_W-2:0], rbit};
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q.rms_level     <= root_q;
					out_q.voiced        <= voiced;
					out_q.activity_on   <= act_next;
					out_q.start_event   <= start_ev;
					out_q.end_event     <= end_ev;
					out_q.forward_audio <= fwd;
				end
			end
			default: begin
				drem_q <= '0;
			end
		endcase
	end

endmodule

/* hw/rtl/rms_voice_activity_detector_top.sv */
// ----------------------------------------------------------------------------
// rms_voice_activity_detector_top: RMS voice activity detector
// Energy detector with a threshold and a silence hangover, fed by PCM
// samples and producing one result per frame.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle unless stalled, and each is squared and
// summed as it arrives. The frame-end sample hands the sum and count to a
// two-entry job queue, and a back end works each frame off in order: it loads
// the job, runs the bit-serial divide of the sum by the count, takes the
// two-bit-per-step square root and runs the activity decision into the
// result register. The sample side stalls only when two frames are already
// waiting, as when frames arrive faster than the back end works them off.
// The frame mean uses the samples counted up to FRAME_SAMPLES; time stamps
// are taken modulo 2^TIME_BITS. Configuration writes are always accepted and
// must be made while the block is idle.
// ----------------------------------------------------------------------------
module rms_voice_activity_detector_top #(
	parameter int FRAME_SAMPLES = 320,
	parameter int TIME_BITS     = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  rvad_pkg::in_t                     sample_data,
	output logic                              result_valid,
	input  logic                              result_stall,
	output rvad_pkg::out_t                    result_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rvad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rvad_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rvad_pkg::cfg_t cfg_q;
	rvad_pkg::job_t push_job;
	rvad_pkg::job_t head_job;
	logic           push;
	logic           queue_full;
	logic           queue_empty;
	logic           pop;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rms_threshold   <= rvad_pkg::THR_RESET;
			cfg_q.silence_hold_us <= rvad_pkg::HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rvad_pkg::CFG_RMS_THRESHOLD: begin
					cfg_q.rms_threshold <= cfg_data[rvad_pkg::THR_W-1:0];
				end
				rvad_pkg::CFG_SILENCE_HOLD_US: begin
					cfg_q.silence_hold_us <= cfg_data[rvad_pkg::HOLD_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	rvad_front #(
		.FRAME_SAMPLES(FRAME_SAMPLES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_data (sample_data),
		.push        (push),
		.push_job    (push_job),
		.queue_full  (queue_full)
	);

	rvad_queue #(
		.DEPTH(2)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (queue_full),
		.pop     (pop),
		.head_job(head_job),
		.empty   (queue_empty)
	);

	rvad_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.job_ready   (!queue_empty),
		.job         (head_job),
		.job_pop     (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

endmodule

/* dv/rms_voice_activity_detector_top_test.sv */
// ----------------------------------------------------------------------------
// rms_voice_activity_detector_top_test: self-checking bench for the RMS VAD
// Drives PCM sample transactions into the detector and predicts each frame
// report: the floor RMS, the voiced decision, and the activity start/end
// flow with the silence hangover. Directed corner frames come first, then
// random frames under several register settings and idle patterns.
// ----------------------------------------------------------------------------
class vad_scoreboard;
	int unsigned                     frame_len;
	logic [rvad_pkg::THR_W-1:0]      thr_level;
	logic [rvad_pkg::HOLD_W-1:0]     hold_us;
	logic [rvad_pkg::SUM_W-1:0]      energy;
	int unsigned                     counted;
	bit                              active;
	bit                              quiet_armed;
	logic [rvad_pkg::TIME_W-1:0]     quiet_since;
	rvad_pkg::out_t                  frame_reports_q[$];
	int                              errors;

	function new(int unsigned frame_len);
		this.frame_len = frame_len;
		thr_level      = rvad_pkg::THR_RESET;
		hold_us        = rvad_pkg::HOLD_RESET;
		energy         = '0;
		counted        = 0;
		active         = 1'b0;
		quiet_armed    = 1'b0;
		quiet_since    = '0;
		errors         = 0;
	endfunction

	function void write_reg(logic [rvad_pkg::CFG_IDX_W-1:0] idx,
			logic [rvad_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			rvad_pkg::CFG_RMS_THRESHOLD: thr_level = value[rvad_pkg::THR_W-1:0];
			rvad_pkg::CFG_SILENCE_HOLD_US: hold_us = value[rvad_pkg::HOLD_W-1:0];
			default: ;
		endcase
	endfunction

	// Largest root whose square does not exceed v
	static function int unsigned floor_root(longint unsigned v);
		int unsigned root;
		int unsigned trial;
		longint unsigned wide;
		root = 0;
		for (int b = 16; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			wide  = 64'(trial);
			if (wide * wide <= v) root = trial;
		end
		return root;
	endfunction

	function void note_sample(rvad_pkg::in_t s);
		longint signed               amp;
		longint unsigned             mean;
		int unsigned                 root;
		logic [rvad_pkg::TIME_W-1:0] span;
		rvad_pkg::out_t              rep;
		// accumulate only up to the frame length
		if (counted < frame_len) begin
			amp     = longint'(s.sample);
			energy  = energy + rvad_pkg::SUM_W'(amp * amp);
			counted = counted + 1;
		end
		if (!s.frame_last) return;

		mean = 64'(energy);
		mean = mean / 64'(counted);
		root = floor_root(mean);
		rep = '0;
		rep.rms_level = root[rvad_pkg::ROOT_W-1:0];
		rep.voiced    = (root >= 32'(thr_level));
		energy  = '0;
		counted = 0;

		// activity decision with silence hangover
		if (s.link_up) begin
			if (rep.voiced) begin
				quiet_armed = 1'b0;
				if (!active && s.start_ok) begin
					active = 1'b1;
					rep.start_event = 1'b1;
				end
				rep.forward_audio = active;
			end else if (active) begin
				if (!quiet_armed) begin
					quiet_armed = 1'b1;
					quiet_since = s.time_us;
				end
				span = s.time_us - quiet_since;
				if (span >= rvad_pkg::TIME_W'(hold_us) && s.end_ok) begin
					active = 1'b0;
					quiet_armed = 1'b0;
					rep.end_event = 1'b1;
				end
			end
		end else begin
			active = 1'b0;
			quiet_armed = 1'b0;
			quiet_since = '0;
		end
		rep.activity_on = active;
		frame_reports_q.push_back(rep);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(rvad_pkg::out_t got);
		rvad_pkg::out_t want;
		if (frame_reports_q.size() == 0) begin
			$display("%0t: frame report expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = frame_reports_q.pop_front();
		compare_field("rms_level", 32'(want.rms_level), 32'(got.rms_level));
		compare_field("voiced", 32'(want.voiced), 32'(got.voiced));
		compare_field("activity_on", 32'(want.activity_on), 32'(got.activity_on));
		compare_field("start_event", 32'(want.start_event), 32'(got.start_event));
		compare_field("end_event", 32'(want.end_event), 32'(got.end_event));
		compare_field("forward_audio", 32'(want.forward_audio), 32'(got.forward_audio));
	endfunction

	function int pending();
		return frame_reports_q.size();
	endfunction
endclass

module rms_voice_activity_detector_top_test;

	localparam int FRAME_LEN       = 320;
	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 9;
	localparam int ITEM_GOAL       = 1850;
	localparam int SEGMENTS        = 12;
	localparam int SETTLE_CYCLES   = 80;
	localparam int STALL_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 500;

	typedef enum int {LEVEL_QUIET, LEVEL_NOISE, LEVEL_FIXED, LEVEL_FULL} level_t;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            sample_valid = 1'b0;
	logic                            sample_stall;
	rvad_pkg::in_t                   sample_data  = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	rvad_pkg::out_t                  result_data;
	logic                            cfg_valid    = 1'b0;
	logic                            cfg_ready;
	logic [rvad_pkg::CFG_IDX_W-1:0]  cfg_index    = rvad_pkg::CFG_RMS_THRESHOLD;
	logic [rvad_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	vad_scoreboard               sb = new(FRAME_LEN);
	int                          send_idle_pct = 27;
	int                          recv_idle_pct = 55;
	int                          hold_off_left = 0;
	int                          items_sent    = 0;
	int                          quiet_cycles  = 0;
	logic [rvad_pkg::TIME_W-1:0] stamp_us      = '0;
	logic [rvad_pkg::THR_W-1:0]  cur_thr       = rvad_pkg::THR_RESET;

	rms_voice_activity_detector_top #(
		.FRAME_SAMPLES(FRAME_LEN),
		.TIME_BITS    (rvad_pkg::TIME_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_data (sample_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [rvad_pkg::TIME_W-1:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic signed [rvad_pkg::SAMPLE_W-1:0] pick_sample(level_t lvl, int mag);
		int v;
		case (lvl)
			LEVEL_QUIET: v = int'($urandom_range(2 * mag)) - mag;
			LEVEL_NOISE: v = int'($urandom_range(65535)) - 32768;
			LEVEL_FIXED: begin
				if (mag >= 32768) v = -32768;
				else begin
					v = (mag < 0) ? 0 : mag;
					if ($urandom_range(1)) v = -v;
				end
			end
			default: v = -32768;
		endcase
		return 16'(v);
	endfunction

	// Move the frame clock: mostly small steps, sometimes long gaps,
	// backward steps or a jump anywhere in the 48-bit range
	function automatic void advance_stamp();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) stamp_us += rvad_pkg::TIME_W'($urandom_range(3000));
		else if (pick < 80) stamp_us += rvad_pkg::TIME_W'($urandom_range(33554432));
		else if (pick < 90) stamp_us -= rvad_pkg::TIME_W'($urandom_range(1, 5000));
		else stamp_us = rand48();
	endfunction

	// Offer one sample transaction and hold it until accepted
	task automatic push_sample(input rvad_pkg::in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_data  <= item;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		sb.note_sample(item);
		items_sent++;
	endtask

	task automatic send_sample(logic signed [rvad_pkg::SAMPLE_W-1:0] value,
			logic [rvad_pkg::TIME_W-1:0] at_us, bit last, bit link, bit s_ok, bit e_ok);
		rvad_pkg::in_t item;
		item.sample     = value;
		item.frame_last = last;
		item.time_us    = at_us;
		item.link_up    = link;
		item.start_ok   = s_ok;
		item.end_ok     = e_ok;
		push_sample(item);
	endtask

	// Inner samples carry random side fields; only the last one counts
	task automatic send_frame(int len, level_t lvl, int mag, bit link, bit s_ok, bit e_ok);
		rvad_pkg::in_t item;
		for (int i = 0; i < len; i++) begin
			item.sample     = pick_sample(lvl, mag);
			item.frame_last = (i == len - 1);
			item.time_us    = item.frame_last ? stamp_us : rand48();
			item.link_up    = item.frame_last ? link : 1'($urandom_range(1));
			item.start_ok   = item.frame_last ? s_ok : 1'($urandom_range(1));
			item.end_ok     = item.frame_last ? e_ok : 1'($urandom_range(1));
			push_sample(item);
		end
	endtask

	task automatic random_frame();
		int     len;
		int     pick;
		int     mag;
		level_t lvl;
		pick = $urandom_range(199);
		if (pick == 0) len = $urandom_range(321, 340);
		else if (pick < 12) len = $urandom_range(40, 200);
		else len = $urandom_range(1, 24);
		pick = $urandom_range(99);
		mag  = 0;
		if (pick < 30) begin
			lvl = LEVEL_QUIET;
			mag = $urandom_range(40);
		end else if (pick < 50) begin
			lvl = LEVEL_NOISE;
		end else if (pick < 85) begin
			// straddle the threshold
			lvl = LEVEL_FIXED;
			mag = int'(cur_thr) + int'($urandom_range(2)) - 1;
		end else if (pick < 92) begin
			lvl = LEVEL_FIXED;
			mag = $urandom_range(32767);
		end else begin
			lvl = LEVEL_FULL;
		end
		advance_stamp();
		send_frame(len, lvl, mag, $urandom_range(99) < 92, $urandom_range(99) < 80,
			$urandom_range(99) < 80);
	endtask

	// Write both registers back to back, then drop the write request
	task automatic program_regs(logic [rvad_pkg::THR_W-1:0] thr,
			logic [rvad_pkg::HOLD_W-1:0] hold);
		logic [rvad_pkg::CFG_DATA_W-1:0] thr_word;
		thr_word  = {8'($urandom), thr};
		cfg_valid <= 1'b1;
		cfg_index <= rvad_pkg::CFG_RMS_THRESHOLD;
		cfg_data  <= thr_word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(rvad_pkg::CFG_RMS_THRESHOLD, thr_word);
		cfg_index <= rvad_pkg::CFG_SILENCE_HOLD_US;
		cfg_data  <= hold;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(rvad_pkg::CFG_SILENCE_HOLD_US, hold);
		cfg_valid <= 1'b0;
		cur_thr = thr;
	endtask

	// Stop offering samples, wait for every report, then let the back end go quiet
	task automatic drain_and_settle();
		sample_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: check accepted reports, then choose the next stall
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) sb.check_result(result_data);
			if (hold_off_left > 0) begin
				result_stall <= 1'b1;
				hold_off_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Abort when no transaction moves on any channel for too long
	initial begin : watchdog
		forever begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int                          seg_goal;
		logic [rvad_pkg::TIME_W-1:0] wrap_edge;
		logic [rvad_pkg::THR_W-1:0]  thr;
		logic [rvad_pkg::HOLD_W-1:0] hold;
		wrap_edge = {rvad_pkg::TIME_W{1'b1}} - 48'd99;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_regs(16'd300, 24'd2000);

		// full-scale frames open an activity
		send_sample(16'h8000, 48'd1000, 1'b1, 1'b1, 1'b1, 1'b1);
		send_sample(16'sd32767, 48'd1500, 1'b1, 1'b1, 1'b1, 1'b1);
		// silence hangover: just short, refused end, then accepted end
		send_sample(16'sd0, 48'd2000, 1'b1, 1'b1, 1'b1, 1'b1);
		send_sample(16'sd0, 48'd3999, 1'b1, 1'b1, 1'b1, 1'b1);
		send_sample(16'sd0, 48'd4000, 1'b1, 1'b1, 1'b1, 1'b0);
		send_sample(16'sd0, 48'd4500, 1'b1, 1'b1, 1'b1, 1'b1);
		// exact threshold with a refused start, one below, then a start
		send_sample(16'sd300, 48'd5000, 1'b1, 1'b1, 1'b0, 1'b1);
		send_sample(16'sd299, 48'd5100, 1'b1, 1'b1, 1'b1, 1'b1);
		send_sample(-16'sd300, 48'd5200, 1'b1, 1'b1, 1'b1, 1'b1);
		// link down clears the activity but still reports the level
		send_sample(16'sd1000, 48'd5300, 1'b1, 1'b0, 1'b1, 1'b1);
		send_sample(16'sd1000, 48'd5400, 1'b1, 1'b1, 1'b1, 1'b1);
		// silence across the time stamp wrap
		send_sample(16'sd0, wrap_edge, 1'b1, 1'b1, 1'b1, 1'b1);
		send_sample(16'sd0, 48'd1000, 1'b1, 1'b1, 1'b1, 1'b1);
		send_sample(16'sd0, 48'd5000, 1'b1, 1'b1, 1'b1, 1'b1);
		// three-sample frame with a floored mean
		send_sample(16'sd32767, rand48(), 1'b0, 1'b0, 1'b0, 1'b0);
		send_sample(16'h8000, rand48(), 1'b0, 1'b1, 1'b1, 1'b1);
		send_sample(16'sd0, 48'd6000, 1'b1, 1'b1, 1'b1, 1'b1);
		// a stamp that runs backwards reads as a long silence
		send_sample(16'sd0, 48'd10000, 1'b1, 1'b1, 1'b1, 1'b1);
		send_sample(16'sd0, 48'd9000, 1'b1, 1'b1, 1'b1, 1'b1);
		stamp_us = 48'd20000;
		drain_and_settle();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 4) begin
				send_idle_pct = 55;
				recv_idle_pct = 27;
			end else if (seg == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (seg % 4)
				0: thr = 16'($urandom_range(50, 3000));
				1: thr = '0;
				2: thr = 16'd32768;
				default: thr = (seg == SEGMENTS - 1) ? '1 : 16'($urandom_range(1, 32767));
			endcase
			case (seg % 3)
				0: hold = 24'($urandom_range(5000));
				1: hold = '0;
				default: hold = '1;
			endcase
			program_regs(thr, hold);

			// hold off the result side while short frames pile up
			if (seg == 0) begin
				hold_off_left = HOLD_OFF_CYCLES;
				repeat (40) begin
					advance_stamp();
					send_frame($urandom_range(1, 3), LEVEL_NOISE, 0, 1'b1, 1'b1, 1'b1);
				end
			end
			// largest sum, then an overlong frame
			if (seg == 2) begin
				advance_stamp();
				send_frame(FRAME_LEN, LEVEL_FULL, 0, 1'b1, 1'b1, 1'b1);
				advance_stamp();
				send_frame(FRAME_LEN + 10, LEVEL_NOISE, 0, 1'b1, 1'b1, 1'b1);
			end

			seg_goal = ITEM_GOAL * (seg + 1) / SEGMENTS;
			while (items_sent < seg_goal) random_frame();
			drain_and_settle();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
